### design/asa_pkg.sv
package asa_pkg;

	// Default depth of the adjustment stack.
	localparam int unsigned MAX_ALLOCATIONS_DEF = 64;

	// Minimum gap left in front of every block.
	localparam int unsigned HEADER_BYTES = 1;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned ADJ_W  = 8;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_REALLOC = 2'd1,
		ACT_DEALLOC = 2'd2,
		ACT_NONE    = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_SPACE = 2'd1,
		STS_STACK = 2'd2
	} sts_code_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_CALC = 2'd1,
		S_EXEC = 2'd2
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic calc;
		logic exec;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

	// Smallest gap >= HEADER_BYTES that aligns the address to 2^lg.
	function automatic logic [ADJ_W-1:0] gap_for(input logic [7:0] addr_lo,
			input logic [2:0] lg);
		logic [8:0] mask;
		logic [8:0] adj;
		logic [8:0] need;
		logic [8:0] up;
		mask = (9'd1 << lg) - 9'd1;
		adj  = (9'd0 - {1'b0, addr_lo}) & mask;
		need = 9'd0;
		up   = 9'd0;
		if (adj < 9'(HEADER_BYTES)) begin
			need = 9'(HEADER_BYTES) - adj;
			up   = ((need + mask) >> lg) << lg;
			adj  = adj + up;
		end
		return adj[ADJ_W-1:0];
	endfunction

endpackage

### design/asa_ctrl.sv
module asa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  asa_pkg::dp_sts_t     sts,
	output asa_pkg::ctrl_cmd_t   cmd
);
	import asa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_CALC;
			end
			S_CALC: begin
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (!sts.out_busy) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = !sts.out_busy;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### design/asa_datapath.sv
module asa_datapath #(
	parameter int unsigned MAX_ALLOCATIONS = asa_pkg::MAX_ALLOCATIONS_DEF,
	parameter int unsigned CNT_W = $clog2(MAX_ALLOCATIONS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  asa_pkg::ctrl_cmd_t        cmd,
	output asa_pkg::dp_sts_t          sts,
	input  logic [31:0]               pool_base,
	input  logic [31:0]               pool_bytes,
	input  logic [1:0]                action,
	input  logic [31:0]               block_address,
	input  logic [31:0]               byte_count,
	input  logic [2:0]                alignment_log2,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [31:0]               result_address,
	output logic [1:0]                status,
	output logic [31:0]               old_size,
	output logic [31:0]               used_total,
	output logic [CNT_W-1:0]          live_count
);
	import asa_pkg::*;

	localparam int unsigned IDX_W = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;

	// Request fields, held from accept to commit.
	act_t        action_q;
	logic [31:0] addr_q;
	logic [31:0] bytes_q;
	logic [2:0]  lg_q;

	// Allocator state.
	logic [CNT_W-1:0] count_q;
	logic [31:0]      top_off_q;
	logic [31:0]      used_q;

	// Adjustment stack.
	logic [ADJ_W-1:0] stack_mem [MAX_ALLOCATIONS];
	logic [ADJ_W-1:0] adj_rd_q;

	// Calculation stage.
	logic [31:0]      top_s1;
	logic [ADJ_W-1:0] adj_s1;
	logic [32:0]      used_adj_s1;
	logic [31:0]      top_off_adj_s1;
	logic [32:0]      end_s1;
	logic [32:0]      pool_end_s1;
	logic [31:0]      old_s1;

	logic [31:0]      top_c;

	// Commit results.
	logic [33:0]      alloc_sum;
	logic [31:0]      res_n;
	sts_code_t        sts_n;
	logic [31:0]      old_n;
	logic [31:0]      used_n;
	logic [31:0]      top_off_n;
	logic [CNT_W-1:0] count_n;
	logic             push;

	logic             out_valid_q;
	logic [31:0]      res_q;
	sts_code_t        sts_q;
	logic [31:0]      old_q;
	logic [31:0]      used_out_q;
	logic [CNT_W-1:0] cnt_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= act_t'(action);
			addr_q   <= block_address;
			bytes_q  <= byte_count;
			lg_q     <= alignment_log2;
		end
	end

	assign top_c = pool_base + top_off_q;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			top_s1         <= top_c;
			adj_s1         <= gap_for(top_c[7:0], lg_q);
			used_adj_s1    <= {1'b0, used_q} + {25'd0, gap_for(top_c[7:0], lg_q)};
			top_off_adj_s1 <= top_off_q + {24'd0, gap_for(top_c[7:0], lg_q)};
			end_s1         <= {1'b0, addr_q} + {1'b0, bytes_q};
			pool_end_s1    <= {1'b0, pool_base} + {1'b0, pool_bytes};
			old_s1         <= top_c - addr_q;
		end
	end

	// Read the top entry ahead of a possible pop.
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			adj_rd_q <= stack_mem[IDX_W'(count_q - CNT_W'(1))];
		end
		if (push) begin
			stack_mem[count_q[IDX_W-1:0]] <= adj_s1;
		end
	end

	assign alloc_sum = {1'b0, used_adj_s1} + {2'd0, bytes_q};

	always_comb begin
		res_n     = 32'd0;
		sts_n     = STS_OK;
		old_n     = 32'd0;
		used_n    = used_q;
		top_off_n = top_off_q;
		count_n   = count_q;
		push      = 1'b0;
		case (action_q)
			ACT_ALLOC: begin
				if (count_q >= CNT_W'(MAX_ALLOCATIONS)) begin
					sts_n = STS_STACK;
				end else if (alloc_sum > {2'd0, pool_bytes}) begin
					sts_n = STS_SPACE;
				end else begin
					res_n     = top_s1 + {24'd0, adj_s1};
					push      = cmd.exec;
					count_n   = count_q + CNT_W'(1);
					top_off_n = top_off_adj_s1 + bytes_q;
					used_n    = alloc_sum[31:0];
				end
			end
			ACT_REALLOC: begin
				if (count_q == '0) begin
					sts_n = STS_STACK;
				end else begin
					old_n = old_s1;
					if (end_s1 > pool_end_s1) begin
						sts_n = STS_SPACE;
					end else begin
						res_n     = addr_q;
						top_off_n = end_s1[31:0] - pool_base;
						used_n    = used_q + bytes_q - old_s1;
					end
				end
			end
			ACT_DEALLOC: begin
				if (addr_q != 32'd0) begin
					if (count_q == '0) begin
						sts_n = STS_STACK;
					end else begin
						count_n   = count_q - CNT_W'(1);
						used_n    = used_q - old_s1 - {24'd0, adj_rd_q};
						top_off_n = addr_q - {24'd0, adj_rd_q} - pool_base;
					end
				end
			end
			default: begin
				sts_n = STS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			top_off_q <= 32'd0;
			used_q    <= 32'd0;
		end else if (cmd.exec) begin
			count_q   <= count_n;
			top_off_q <= top_off_n;
			used_q    <= used_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q      <= res_n;
			sts_q      <= sts_n;
			old_q      <= old_n;
			used_out_q <= used_n;
			cnt_out_q  <= count_n;
		end
	end

	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign result_address = res_q;
	assign status         = sts_q;
	assign old_size       = old_q;
	assign used_total     = used_out_q;
	assign live_count     = cnt_out_q;

endmodule

### design/aligned_stack_allocator_top.sv
// LIFO bump allocator over a pool set by pool_base (0x0) and pool_bytes (0x4).
// Each request item on s_* allocates an aligned block, resizes or frees the top
// block, or does nothing, and yields exactly one result item on m_*. An item
// passes through accept, an address/adjustment stage that also reads the
// top of the adjustment stack memory into a register, and a commit step that
// updates the allocator state and loads the result register. The controller
// handles one item at a time, so no new item is accepted before the last one
// has committed; a stalled m_tready holds the commit until the result register frees,
// while a result waiting in that register does not block the next accept.
// The stack is undefined after reset and needs no clearing pass: an entry is
// used only after it was pushed. Write the pool registers only while idle.
module aligned_stack_allocator_top #(
	parameter int unsigned MAX_ALLOCATIONS = asa_pkg::MAX_ALLOCATIONS_DEF,
	parameter int unsigned CNT_W = $clog2(MAX_ALLOCATIONS + 1),
	parameter int unsigned OUT_W = ((96 + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// APB register port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// request items
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [71:0]      s_tdata,  // block_address, byte_count, alignment_log2
	input  logic [1:0]       s_tuser,  // action
	// result items
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // result_address, old_size, used_total, live_count
	output logic [1:0]       m_tuser   // status
);
	import asa_pkg::*;

	localparam logic [2:0] ADDR_POOL_BASE  = 3'd0;
	localparam logic [2:0] ADDR_POOL_BYTES = 3'd4;

	logic [31:0]      pool_base_q;
	logic [31:0]      pool_bytes_q;
	logic             cfg_wr;

	ctrl_cmd_t        cmd;
	dp_sts_t          sts;

	logic [31:0]      result_address;
	logic [31:0]      old_size;
	logic [31:0]      used_total;
	logic [CNT_W-1:0] live_count;

	// Registers decode on bit 2 alone; the low bits are byte lanes.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= 32'd0;
			pool_bytes_q <= 32'd0;
		end else if (cfg_wr) begin
			if (paddr[2] == ADDR_POOL_BYTES[2]) begin
				pool_bytes_q <= pwdata;
			end else begin
				pool_base_q <= pwdata;
			end
		end
	end

	always_comb begin
		if (paddr[2] == ADDR_POOL_BASE[2]) begin
			prdata = pool_base_q;
		end else begin
			prdata = pool_bytes_q;
		end
	end

	asa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	asa_datapath #(
		.MAX_ALLOCATIONS (MAX_ALLOCATIONS),
		.CNT_W           (CNT_W)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.pool_base      (pool_base_q),
		.pool_bytes     (pool_bytes_q),
		.action         (s_tuser),
		.block_address  (s_tdata[31:0]),
		.byte_count     (s_tdata[63:32]),
		.alignment_log2 (s_tdata[66:64]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.result_address (result_address),
		.status         (m_tuser),
		.old_size       (old_size),
		.used_total     (used_total),
		.live_count     (live_count)
	);

	// Pack the result item; pad with zeros to whole bytes.
	always_comb begin
		m_tdata                = '0;
		m_tdata[31:0]          = result_address;
		m_tdata[63:32]         = old_size;
		m_tdata[95:64]         = used_total;
		m_tdata[96 +: CNT_W]   = live_count;
	end

`ifndef SYNTHESIS
	// One item in flight: no accept in the cycle after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is in flight");

	// The live count never passes the stack depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (live_count <= CNT_W'(MAX_ALLOCATIONS)))
		else $error("live count beyond stack depth");

	// A failed request never returns an address.
	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STS_SPACE || m_tuser == STS_STACK))
		|-> (result_address == 32'd0))
		else $error("address returned on failure");
`endif

endmodule

### bench/aligned_stack_allocator_top_tb.sv
module aligned_stack_allocator_top_tb;
	import asa_pkg::*;

	// Register byte addresses on the APB port.
	localparam logic [2:0] REG_POOL_BASE  = 3'd0;
	localparam logic [2:0] REG_POOL_BYTES = 3'd4;

	localparam int STACK_DEPTH   = MAX_ALLOCATIONS_DEF;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 180;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT  = 10;

	// One result item, unpacked from m_tdata / m_tuser.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] address;
		logic [31:0] old_size;
		logic [31:0] used_total;
		logic [6:0]  live_count;
	} alloc_result_t;

	// Shadow copy of the allocator: predicts one result per request and
	// checks the results in order.
	class allocator_checker;
		bit [31:0] pool_base;
		bit [31:0] pool_bytes;
		bit [31:0] top_offset;
		bit [31:0] used_bytes;
		bit [6:0]  live;
		bit [7:0]  gap_stack [STACK_DEPTH];
		bit [31:0] live_blocks [$];
		alloc_result_t pending_results [$];
		int mismatches;

		function void write_reg(bit [2:0] addr, bit [31:0] value);
			if (addr == REG_POOL_BASE)
				pool_base = value;
			else if (addr == REG_POOL_BYTES)
				pool_bytes = value;
		endfunction

		function bit [31:0] gap_to_align(bit [31:0] addr, bit [2:0] lg);
			bit [31:0] align;
			bit [31:0] gap;
			align = 32'd1 << lg;
			gap = (32'd0 - addr) & (align - 32'd1);
			while (gap < HEADER_BYTES)
				gap = gap + align;
			return gap;
		endfunction

		function void predict_request(act_t act, bit [31:0] addr, bit [31:0] bytes,
				bit [2:0] lg);
			bit [31:0] top;
			bit [31:0] gap;
			alloc_result_t r;
			top = pool_base + top_offset;
			r.status = STS_OK;
			r.address = '0;
			r.old_size = '0;
			case (act)
			ACT_ALLOC: begin
				gap = gap_to_align(top, lg);
				if (live >= STACK_DEPTH)
					r.status = STS_STACK;
				else if ({32'd0, used_bytes} + gap + bytes > {32'd0, pool_bytes})
					r.status = STS_SPACE;
				else begin
					r.address = top + gap;
					gap_stack[live] = gap[7:0];
					live = live + 7'd1;
					top_offset = top_offset + gap + bytes;
					used_bytes = used_bytes + gap + bytes;
					live_blocks.push_back(top + gap);
				end
			end
			ACT_REALLOC: begin
				if (live == 0)
					r.status = STS_STACK;
				else begin
					r.old_size = top - addr;
					if ({32'd0, addr} + bytes > {32'd0, pool_base} + pool_bytes)
						r.status = STS_SPACE;
					else begin
						r.address = addr;
						top_offset = addr + bytes - pool_base;
						used_bytes = used_bytes + bytes - (top - addr);
						live_blocks[live_blocks.size() - 1] = addr;
					end
				end
			end
			ACT_DEALLOC: begin
				if (addr != 0) begin
					if (live == 0)
						r.status = STS_STACK;
					else begin
						live = live - 7'd1;
						gap = {24'd0, gap_stack[live]};
						used_bytes = used_bytes - ((top - addr) + gap);
						top_offset = addr - gap - pool_base;
						void'(live_blocks.pop_back());
					end
				end
			end
			default: ;
			endcase
			r.used_total = used_bytes;
			r.live_count = live;
			pending_results.push_back(r);
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result item: status %0d address %h",
						got.status, got.address);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.address !== want.address ||
					got.old_size !== want.old_size || got.used_total !== want.used_total ||
					got.live_count !== want.live_count) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display({"result mismatch: status %0d/%0d address %h/%h old_size %h/%h",
						" used_total %h/%h live_count %0d/%0d (expected/actual)"},
						want.status, got.status, want.address, got.address,
						want.old_size, got.old_size, want.used_total, got.used_total,
						want.live_count, got.live_count);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;  // block_address, byte_count, alignment_log2
	logic [1:0]   s_tuser = ACT_NONE;  // action
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;  // result_address, old_size, used_total, live_count
	logic [1:0]   m_tuser;  // status

	allocator_checker sb;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	aligned_stack_allocator_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the result side at random; stall_pct set per phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Check every accepted result item against the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status     = m_tuser;
			got.address    = m_tdata[31:0];
			got.old_size   = m_tdata[63:32];
			got.used_total = m_tdata[95:64];
			got.live_count = m_tdata[102:96];
			sb.check_result(got);
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[aligned_stack_allocator_top] ERROR");
			$finish;
		end
	end

	// Write one pool register with a setup and an access phase.
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(addr, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one request item, idling first at random, and hold it until accepted.
	task automatic send_request(act_t act, bit [31:0] addr, bit [31:0] bytes, bit [2:0] lg);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {5'd0, lg, bytes, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.predict_request(act, addr, bytes, lg);
	endtask

	// Drop valid and hold off until every expected result has arrived.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Free the live blocks from the top down.
	task automatic unwind_blocks();
		int n;
		n = sb.live;
		repeat (n)
			send_request(ACT_DEALLOC, sb.live_blocks[sb.live_blocks.size() - 1],
				$urandom, 3'($urandom_range(0, 7)));
	endtask

	// Mostly small sizes; zero and full-range sizes now and then.
	function automatic bit [31:0] pick_size();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 32'd0;
		else if (r == 1)
			return $urandom;
		return $urandom_range(1, 48);
	endfunction

	// Mostly well-formed traffic on the top block; the rest is raw noise.
	task automatic random_request(int alloc_pct);
		act_t act;
		bit [31:0] addr;
		bit [31:0] bytes;
		bit [2:0] lg;
		lg = 3'($urandom_range(0, 7));
		addr = $urandom;
		if ($urandom_range(0, 99) < 12) begin
			act = act_t'(2'($urandom_range(0, 3)));
			bytes = $urandom;
			if ($urandom_range(0, 3) == 0)
				addr = '0;
		end else begin
			bytes = pick_size();
			if (sb.live == 0 || $urandom_range(0, 99) < alloc_pct)
				act = ACT_ALLOC;
			else begin
				act = ($urandom_range(0, 2) == 0) ? ACT_REALLOC : ACT_DEALLOC;
				addr = sb.live_blocks[sb.live_blocks.size() - 1];
			end
		end
		send_request(act, addr, bytes, lg);
	endtask

	initial begin
		bit [31:0] first_blk;
		bit [31:0] blk;
		int alloc_pct;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty-stack cases, header and full alignment, zero size,
		// space failures, null and stale addresses, wrap at the top of memory.
		write_reg(REG_POOL_BASE, 32'h0000_1000);
		write_reg(REG_POOL_BYTES, 32'h0000_0100);
		send_request(ACT_DEALLOC, 32'h0, 32'h5, 3'd0);
		send_request(ACT_DEALLOC, 32'h1234, 32'h0, 3'd0);
		send_request(ACT_REALLOC, 32'h1000, 32'h8, 3'd3);
		send_request(ACT_NONE, 32'hffff_ffff, 32'hffff_ffff, 3'd7);
		send_request(ACT_ALLOC, 32'h0, 32'h10, 3'd0);
		first_blk = sb.live_blocks[0];
		send_request(ACT_ALLOC, 32'hffff_ffff, 32'h20, 3'd7);
		send_request(ACT_ALLOC, 32'h0, 32'h0, 3'd3);
		send_request(ACT_ALLOC, 32'h0, 32'hffff_ffff, 3'd7);
		blk = sb.live_blocks[sb.live_blocks.size() - 1];
		send_request(ACT_REALLOC, blk, 32'h8, 3'd0);
		send_request(ACT_REALLOC, blk, 32'hffff_ffff, 3'd0);
		send_request(ACT_REALLOC, 32'h0, 32'h10, 3'd0);
		send_request(ACT_REALLOC, blk, 32'h4, 3'd0);
		send_request(ACT_ALLOC, 32'h0, 32'h1, 3'd5);
		send_request(ACT_DEALLOC, first_blk, 32'h0, 3'd0);
		send_request(ACT_ALLOC, 32'h0, 32'hc8, 3'd2);
		unwind_blocks();
		drain_results();

		// Pool just below the top of the address space: the first block wraps to 0.
		write_reg(REG_POOL_BASE, 32'hffff_fff0);
		write_reg(REG_POOL_BYTES, 32'h0000_0040);
		send_request(ACT_ALLOC, 32'h0, 32'h10, 3'd4);
		send_request(ACT_ALLOC, 32'h0, 32'h8, 3'd0);
		send_request(ACT_ALLOC, 32'h0, 32'h40, 3'd1);
		unwind_blocks();

		// Random part: one pool setting and one idle pattern per phase.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			case (p)
			0: begin
				write_reg(REG_POOL_BASE, 32'h0);
				write_reg(REG_POOL_BYTES, 32'hffff_ffff);
			end
			1: begin
				write_reg(REG_POOL_BASE, 32'h0000_1003);
				write_reg(REG_POOL_BYTES, 32'd4096);
			end
			2: begin
				write_reg(REG_POOL_BASE, 32'hffff_f000);
				write_reg(REG_POOL_BYTES, 32'h0000_2000);
			end
			3: begin
				write_reg(REG_POOL_BASE, 32'hffff_ffff);
				write_reg(REG_POOL_BYTES, 32'h0);
			end
			4: begin
				write_reg(REG_POOL_BASE, $urandom);
				write_reg(REG_POOL_BYTES, $urandom_range(256, 65536));
			end
			5: begin
				write_reg(REG_POOL_BASE, 32'h8000_0000);
				write_reg(REG_POOL_BYTES, 32'd600);
			end
			6: begin
				write_reg(REG_POOL_BASE, $urandom);
				write_reg(REG_POOL_BYTES, 32'hffff_ffff);
			end
			default: begin
				write_reg(REG_POOL_BASE, 32'h0000_0010);
				write_reg(REG_POOL_BYTES, 32'h0000_0800);
			end
			endcase
			case (p % 4)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 64;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 64;
			end
			default: begin
				idle_pct = 35;
				stall_pct = 35;
			end
			endcase
			// Grow phases push the stack past its depth.
			alloc_pct = (p == 0 || p == 6) ? 85 : 45;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Pause the sender mid-phase until the result side is empty.
				if (i == PHASE_ITEMS / 2)
					drain_results();
				random_request(alloc_pct);
			end
			unwind_blocks();
		end

		idle_pct = 0;
		stall_pct = 0;
		drain_results();
		if (sb.mismatches == 0)
			$display("[aligned_stack_allocator_top] OK");
		else
			$display("[aligned_stack_allocator_top] ERROR");
		$finish;
	end

endmodule

### files.f
design/asa_pkg.sv
design/asa_ctrl.sv
design/asa_datapath.sv
design/aligned_stack_allocator_top.sv
bench/aligned_stack_allocator_top_tb.sv
